// ----- rtl/ptcs_pkg.sv -----
// shared types, codes and sizes for the periodic task countdown scheduler
// no dependencies; used by every module of the block by scoped names
package ptcs_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int RESULT_LIMIT  = 16;
    localparam int RCW           = $clog2(RESULT_LIMIT + 1);
    localparam int QDEPTH        = 2;
    localparam int QAW           = 1;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_ADD   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_ZERO = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] interval;
        logic [15:0] task_tag;
    } cmd_word_t;

    typedef struct packed {
        logic [15:0] fired_tag;
        logic        fired;
        logic [1:0]  status;
        logic        last;
    } result_word_t;

    typedef struct packed {
        logic [1:0]  op;
        logic        zero_interval;
        logic [15:0] interval;
        logic [15:0] task_tag;
    } queue_word_t;

endpackage

// ----- rtl/ptcs_front.sv -----
// front end: takes command words and classifies them into queue words
// depends on ptcs_pkg
module ptcs_front
(
    input  logic                   start,
    input  logic                   busy,
    input  ptcs_pkg::cmd_word_t    command,
    output logic                   push,
    output ptcs_pkg::queue_word_t  entry
);

    always_comb
    begin
        push                = start && !busy;
        entry.interval      = command.interval;
        entry.task_tag      = command.task_tag;
        entry.zero_interval = (command.interval == 16'd0);
        case (command.action)
            ptcs_pkg::ACT_TICK:  entry.op = ptcs_pkg::OP_TICK;
            ptcs_pkg::ACT_ADD:   entry.op = ptcs_pkg::OP_ADD;
            ptcs_pkg::ACT_CLEAR: entry.op = ptcs_pkg::OP_CLEAR;
            default:             entry.op = ptcs_pkg::OP_NOP;
        endcase
    end

endmodule

// ----- rtl/ptcs_queue.sv -----
// two-word queue between front end and execution unit
// depends on ptcs_pkg
module ptcs_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ptcs_pkg::queue_word_t  push_word,
    input  logic                   pop,
    output ptcs_pkg::queue_word_t  head,
    output logic                   empty,
    output logic                   full
);

    ptcs_pkg::queue_word_t             slot_reg [ptcs_pkg::QDEPTH];
    logic [ptcs_pkg::QAW-1:0]          wr_ptr_reg;
    logic [ptcs_pkg::QAW-1:0]          wr_ptr_next;
    logic [ptcs_pkg::QAW-1:0]          rd_ptr_reg;
    logic [ptcs_pkg::QAW-1:0]          rd_ptr_next;
    logic [ptcs_pkg::QAW:0]            fill_reg;
    logic [ptcs_pkg::QAW:0]            fill_next;

    assign empty = (fill_reg == '0);
    assign full  = (fill_reg == (ptcs_pkg::QAW+1)'(ptcs_pkg::QDEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ----- rtl/ptcs_back.sv -----
// execution unit: task table memories, add/clear handling and the tick scan
// depends on ptcs_pkg
module ptcs_back
#(
    parameter int MAX_TASKS = ptcs_pkg::MAX_TASKS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ptcs_pkg::queue_word_t   head,
    input  logic                    empty,
    output logic                    pop,
    output logic                    strobe,
    output ptcs_pkg::result_word_t  result
);

    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_SCAN = 1'b1;

    logic [15:0] period_mem    [MAX_TASKS];
    logic [15:0] countdown_mem [MAX_TASKS];
    logic [15:0] tag_mem       [MAX_TASKS];

    logic [0:0]               state_reg,     state_next;
    logic [CW-1:0]            count_reg,     count_next;
    logic [AW-1:0]            scan_reg,      scan_next;
    logic                     issue_reg,     issue_next;
    logic                     pvld_reg,      pvld_next;
    logic [AW-1:0]            pidx_reg,      pidx_next;
    logic [ptcs_pkg::RCW-1:0] n_reg,         n_next;
    logic                     pend_vld_reg,  pend_vld_next;
    logic [15:0]              pend_tag_reg,  pend_tag_next;
    logic                     strobe_reg,    strobe_next;
    ptcs_pkg::result_word_t   result_reg,    result_next;

    logic [15:0]   rd_cd_reg;
    logic [15:0]   rd_per_reg;
    logic [15:0]   rd_tag_reg;
    logic [15:0]   dec;
    logic [CW-1:0] count_m1;
    logic          add_we;
    logic          cd_we;
    logic [AW-1:0] cd_wa;
    logic [15:0]   cd_wd;

    assign strobe   = strobe_reg;
    assign result   = result_reg;
    assign dec      = rd_cd_reg - 16'd1;
    assign count_m1 = count_reg - CW'(1);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        issue_next    = issue_reg;
        pvld_next     = 1'b0;
        pidx_next     = pidx_reg;
        n_next        = n_reg;
        pend_vld_next = pend_vld_reg;
        pend_tag_next = pend_tag_reg;
        strobe_next   = 1'b0;
        result_next   = result_reg;
        pop           = 1'b0;
        add_we        = 1'b0;
        cd_we         = 1'b0;
        cd_wa         = count_reg[AW-1:0];
        cd_wd         = head.interval;
        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop                   = 1'b1;
                    strobe_next           = 1'b1;
                    result_next.fired_tag = 16'd0;
                    result_next.fired     = 1'b0;
                    result_next.status    = ptcs_pkg::STATUS_OK;
                    result_next.last      = 1'b1;
                    case (head.op)
                        ptcs_pkg::OP_ADD:
                        begin
                            if (head.zero_interval)
                            begin
                                result_next.status = ptcs_pkg::STATUS_ZERO;
                            end
                            else if (count_reg >= CW'(MAX_TASKS))
                            begin
                                result_next.status = ptcs_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                add_we     = 1'b1;
                                cd_we      = 1'b1;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ptcs_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        ptcs_pkg::OP_TICK:
                        begin
                            if (count_reg != '0)
                            begin
                                strobe_next   = 1'b0;
                                state_next    = ST_SCAN;
                                scan_next     = count_m1[AW-1:0];
                                issue_next    = 1'b1;
                                n_next        = '0;
                                pend_vld_next = 1'b0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (issue_reg)
                begin
                    pvld_next = 1'b1;
                    pidx_next = scan_reg;
                    if (scan_reg == '0)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        scan_next = scan_reg - AW'(1);
                    end
                end
                if (pvld_reg)
                begin
                    cd_we = 1'b1;
                    cd_wa = pidx_reg;
                    cd_wd = dec;
                    if (dec == 16'd0)
                    begin
                        cd_wd = rd_per_reg;
                        if (n_reg < ptcs_pkg::RCW'(ptcs_pkg::RESULT_LIMIT))
                        begin
                            n_next        = n_reg + 1'b1;
                            pend_vld_next = 1'b1;
                            pend_tag_next = rd_tag_reg;
                            if (pend_vld_reg)
                            begin
                                // hand out the held one, the new one may be the last
                                strobe_next           = 1'b1;
                                result_next.fired_tag = pend_tag_reg;
                                result_next.fired     = 1'b1;
                                result_next.status    = ptcs_pkg::STATUS_OK;
                                result_next.last      = 1'b0;
                            end
                        end
                    end
                end
                if (!issue_reg && !pvld_reg)
                begin
                    state_next            = ST_IDLE;
                    strobe_next           = 1'b1;
                    result_next.fired_tag = pend_vld_reg ? pend_tag_reg : 16'd0;
                    result_next.fired     = pend_vld_reg;
                    result_next.status    = ptcs_pkg::STATUS_OK;
                    result_next.last      = 1'b1;
                    pend_vld_next         = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            issue_reg    <= 1'b0;
            pvld_reg     <= 1'b0;
            n_reg        <= '0;
            pend_vld_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            issue_reg    <= issue_next;
            pvld_reg     <= pvld_next;
            n_reg        <= n_next;
            pend_vld_reg <= pend_vld_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        pidx_reg     <= pidx_next;
        pend_tag_reg <= pend_tag_next;
        result_reg   <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (add_we)
        begin
            period_mem[count_reg[AW-1:0]] <= head.interval;
            tag_mem[count_reg[AW-1:0]]    <= head.task_tag;
        end
        if (cd_we)
        begin
            countdown_mem[cd_wa] <= cd_wd;
        end
        rd_cd_reg  <= countdown_mem[scan_reg];
        rd_per_reg <= period_mem[scan_reg];
        rd_tag_reg <= tag_mem[scan_reg];
    end

endmodule

// ----- rtl/periodic_task_countdown_scheduler_core.sv -----
// top level of the periodic task countdown scheduler
// depends on ptcs_pkg, ptcs_front, ptcs_queue and ptcs_back
//
// A command word is taken when start is high and busy is low; busy is high only while the
// two-word command queue is full. Every command gives one or more result words, each shown
// for one cycle with strobe high; the receiver cannot stall them, and last marks the final
// word of a command. Add, clear, the unused action and a tick on an empty table are handled
// in the idle state of the execution unit; their word passes the queue slot and the result
// register. A tick walks the task table newest first through one memory read port, one
// task per cycle, and gives its last word once the walk is done; fired words come out
// during the walk. The queue absorbs the next commands meanwhile.
module periodic_task_countdown_scheduler_core
#(
    parameter int MAX_TASKS = ptcs_pkg::MAX_TASKS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  ptcs_pkg::cmd_word_t     command,
    output logic                    strobe,
    output ptcs_pkg::result_word_t  result
);

    logic                  push;
    logic                  pop;
    logic                  empty;
    ptcs_pkg::queue_word_t entry;
    ptcs_pkg::queue_word_t head;

    ptcs_front u_front
    (
        .start   (start),
        .busy    (busy),
        .command (command),
        .push    (push),
        .entry   (entry)
    );

    ptcs_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (entry),
        .pop       (pop),
        .head      (head),
        .empty     (empty),
        .full      (busy)
    );

    ptcs_back #(.MAX_TASKS(MAX_TASKS)) u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .empty  (empty),
        .pop    (pop),
        .strobe (strobe),
        .result (result)
    );

`ifndef SYNTHESIS
    a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.fired |-> result.status == ptcs_pkg::STATUS_OK)
        else $error("fired word with error status");

    a_idle_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.fired |-> result.fired_tag == 16'd0 && result.last)
        else $error("non-fired word with tag or without last");

    a_error_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.status != ptcs_pkg::STATUS_OK |-> result.last)
        else $error("refused add not marked last");

    a_pop_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue popped while empty");
`endif

endmodule
